// File: src/assert_macros.svh
// Assertion macros used by the presence table top level.
// Depends on nothing; included by files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define CHECK_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication checked on the next clock edge.
`define CHECK_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

// File: src/bpt_pkg.sv
// Package of the beacon presence table: widths, event codes and shared types.
// Depends on nothing.
package bpt_pkg;

   localparam int TableDepth = 32;
   localparam int SlotW = 5;
   localparam int TimeW = 48;
   localparam int AgeW = 40;
   localparam int CsrDataW = 40;
   localparam int CsrIdxW = 1;

   // Channel payload widths: request is type, major, minor, rssi, ref power,
   // time; result is event, slot, major, minor, rssi, ref power, removed, last.
   localparam int ReqW = 1 + 16 + 16 + 8 + 8 + TimeW;
   localparam int RspW = 3 + SlotW + 16 + 16 + 8 + 8 + 1 + 1;

   localparam logic [7:0] RssiThrReset = 8'h9C;
   localparam logic [AgeW-1:0] AgeLimitReset = 40'd10000000;

   localparam logic CsrRssiThr = 1'b0;
   localparam logic CsrAgeLimit = 1'b1;

   localparam logic ReqSight = 1'b0;
   localparam logic ReqSweep = 1'b1;

   localparam logic [2:0] EvRefresh = 3'd0;
   localparam logic [2:0] EvAdded = 3'd1;
   localparam logic [2:0] EvInserted = 3'd2;
   localparam logic [2:0] EvWeak = 3'd3;
   localparam logic [2:0] EvFull = 3'd4;
   localparam logic [2:0] EvRemoved = 3'd5;

   // One stored tag.
   typedef struct packed {
      logic [15:0] major;
      logic [15:0] minor;
      logic [7:0] rssi;
      logic [7:0] ref_power;
      logic standing;
      logic [TimeW-1:0] seen;
   } entry_type;

   // Command broadcast from the controller to every cell.
   typedef struct packed {
      logic shift;      // every cell not being written takes its right neighbor
      logic write;      // write the addressed cell
      logic [8:0] widx; // addressed cell (wide enough for depths up to 512)
      logic refresh;    // refresh only: set standing and time
   } cell_cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_SWEEP, ST_EMIT, ST_DONE
   } state_type;

endpackage

// File: src/bpt_if.sv
// Valid/ready channel interface used on both sides of the presence table.
// Depends on nothing; payload width is a parameter.
interface bpt_if #(parameter int W = 8);
   logic valid;
   logic ready;
   logic [W-1:0] payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: src/beacon_presence_table.sv
// Top level of the beacon presence table: controller and cell row.
// Depends on bpt_pkg, bpt_if, bpt_chain and assert_macros.svh.
//
//  channel | direction | payload
//  req     | in        | req_type, major_id, minor_id, rssi, ref_power, now_us
//  rsp     | out       | event_res, slot, tag fields, sweep_removed, last
//  csr     | in        | write enable, index, 40-bit data
//
// A sighting rotates the row of DEPTH cells once; no new item is taken until it ends.
// A sweep rotates once as well, compacting removed entries; each result waits
// in the output register until taken, stalling the rotation.
// A sighting's result waits in the last step while the output register is full.
// Reset clears count, state and output valid and presets the configuration registers; cell contents are not reset.
`include "assert_macros.svh"
module beacon_presence_table #(parameter int DEPTH = bpt_pkg::TableDepth) (
   input  logic clock,
   input  logic reset,
   bpt_if.sink req,
   bpt_if.source rsp,
   input  logic csr_we,
   input  logic [bpt_pkg::CsrIdxW-1:0] csr_idx,
   input  logic [bpt_pkg::CsrDataW-1:0] csr_data
);
   localparam int CntW = $clog2(DEPTH + 1);
   localparam int IdxW = $clog2(DEPTH);

   bpt_pkg::state_type state_ff, state_in;
   logic [7:0] thr_ff;
   logic [bpt_pkg::AgeW-1:0] age_ff;
   logic [CntW-1:0] count_ff, count_in;
   logic [CntW-1:0] step_ff, step_in;     // rotation steps done
   logic [CntW-1:0] kept_ff, kept_in;     // entries kept so far in a sweep
   logic [IdxW-1:0] hit_ff, hit_in;
   logic found_ff, found_in;
   logic [bpt_pkg::ReqW-1:0] req_ff;
   logic [bpt_pkg::RspW-1:0] out_ff, out_in;
   logic [bpt_pkg::RspW-1:0] hit_out_ff, hit_out_in;
   logic ovalid_ff, ovalid_in;
   bpt_pkg::cell_cmd_type cmd;
   bpt_pkg::entry_type head, wdata;

   // Request fields.
   logic r_type;
   logic [15:0] r_maj, r_min;
   logic [7:0] r_rs, r_rp;
   logic [47:0] r_now;
   assign {r_type, r_maj, r_min, r_rs, r_rp, r_now} = req_ff;

   // Payload packing: ev, slot, major, minor, rssi, refp, removed, last.
   function automatic logic [bpt_pkg::RspW-1:0] pack(logic [2:0] ev, logic [4:0] sl,
         logic [15:0] mj, logic [15:0] mn, logic [7:0] rs, logic [7:0] rp,
         logic rem, logic lst);
      return {ev, sl, mj, mn, rs, rp, rem, lst};
   endfunction

   // Age and match tests on the head cell.
   logic [47:0] diff;
   logic stale, in_use, match;
   assign diff = (r_now >= head.seen) ? r_now - head.seen : head.seen - r_now;
   assign stale = diff > {8'd0, age_ff};
   assign in_use = step_ff < count_ff;
   assign match = in_use && head.major == r_maj && head.minor == r_min;

   assign wdata = '{major: r_maj, minor: r_min, rssi: r_rs, ref_power: r_rp,
                    standing: 1'b0, seen: r_now};

   logic in_idle, sweeping;
   assign in_idle = (state_ff == bpt_pkg::ST_IDLE);
   assign sweeping = (state_ff == bpt_pkg::ST_SWEEP);

   assign req.ready = in_idle;
   assign rsp.valid = ovalid_ff;
   assign rsp.payload = out_ff;

   logic obusy;
   assign obusy = ovalid_ff && !rsp.ready;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= bpt_pkg::RssiThrReset;
         age_ff <= bpt_pkg::AgeLimitReset;
      end else if (csr_we) begin
         case (csr_idx)
            bpt_pkg::CsrRssiThr: thr_ff <= csr_data[7:0];
            bpt_pkg::CsrAgeLimit: age_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bpt_pkg::ST_IDLE:
            if (req.valid)
               state_in = (req.payload[bpt_pkg::ReqW-1] == bpt_pkg::ReqSweep) ?
                          bpt_pkg::ST_SWEEP : bpt_pkg::ST_SCAN;
         bpt_pkg::ST_SCAN:
            if (step_ff == CntW'(DEPTH)) state_in = bpt_pkg::ST_EMIT;
         bpt_pkg::ST_SWEEP:
            if (!obusy && step_ff == CntW'(DEPTH)) state_in = bpt_pkg::ST_DONE;
         bpt_pkg::ST_EMIT:
            if (!obusy) state_in = bpt_pkg::ST_IDLE;
         bpt_pkg::ST_DONE:
            if (!obusy) state_in = bpt_pkg::ST_IDLE;
         default: state_in = bpt_pkg::ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      cmd = '0;
      count_in = count_ff;
      step_in = step_ff;
      kept_in = kept_ff;
      hit_in = hit_ff;
      found_in = found_ff;
      hit_out_in = hit_out_ff;
      out_in = out_ff;
      ovalid_in = ovalid_ff && !rsp.ready;
      case (state_ff)
         bpt_pkg::ST_IDLE: begin
            step_in = '0;
            kept_in = '0;
            found_in = 1'b0;
         end
         bpt_pkg::ST_SCAN: begin
            // Rotate a full turn; remember the first match.
            if (step_ff != CntW'(DEPTH)) begin
               cmd.shift = 1'b1;
               step_in = step_ff + 1'b1;
               if (match && !found_ff) begin
                  found_in = 1'b1;
                  hit_in = IdxW'(step_ff);
                  hit_out_in = pack(head.standing ? bpt_pkg::EvRefresh : bpt_pkg::EvAdded,
                                    5'(step_ff), head.major, head.minor, head.rssi,
                                    head.ref_power, 1'b0, 1'b1);
               end
            end
         end
         bpt_pkg::ST_EMIT: begin
            if (!obusy) begin
               ovalid_in = 1'b1;
               if (found_ff) begin
                  cmd.write = 1'b1;
                  cmd.refresh = 1'b1;
                  cmd.widx = 9'(hit_ff);
                  out_in = hit_out_ff;
               end else if ($signed(r_rs) < $signed(thr_ff)) begin
                  out_in = pack(bpt_pkg::EvWeak, 5'd0, r_maj, r_min, r_rs, r_rp,
                                1'b0, 1'b1);
               end else if (count_ff >= CntW'(DEPTH)) begin
                  out_in = pack(bpt_pkg::EvFull, 5'd0, r_maj, r_min, r_rs, r_rp,
                                1'b0, 1'b1);
               end else begin
                  cmd.write = 1'b1;
                  cmd.widx = 9'(count_ff);
                  count_in = count_ff + 1'b1;
                  out_in = pack(bpt_pkg::EvInserted, 5'(count_ff), r_maj, r_min,
                                r_rs, r_rp, 1'b0, 1'b1);
               end
            end
         end
         bpt_pkg::ST_SWEEP: begin
            // Each step examines the head; stale entries are dropped and
            // standing ones reported at their compacted position.
            if (!obusy && step_ff != CntW'(DEPTH)) begin
               cmd.shift = 1'b1;
               step_in = step_ff + 1'b1;
               if (in_use) begin
                  if (stale) begin
                     if (head.standing) begin
                        ovalid_in = 1'b1;
                        out_in = pack(bpt_pkg::EvRemoved, 5'(kept_ff), head.major,
                                      head.minor, head.rssi, head.ref_power,
                                      1'b1, 1'b0);
                     end
                  end else begin
                     kept_in = kept_ff + 1'b1;
                  end
               end
            end
         end
         bpt_pkg::ST_DONE: begin
            if (!obusy) begin
               ovalid_in = 1'b1;
               count_in = kept_ff;
               out_in = pack(bpt_pkg::EvRemoved, 5'd0, 16'd0, 16'd0, 8'd0, 8'd0,
                             1'b0, 1'b1);
            end
         end
         default: ;
      endcase
   end

   // Sweep compaction: after the shift, the entries kept so far sit in order
   // just above the cells not yet visited, so a kept head is written right
   // behind them. After a full turn the kept entries fill the low cells.
   bpt_pkg::cell_cmd_type cmd_x;
   bpt_pkg::entry_type wsel;
   logic [IdxW-1:0] dst;
   assign dst = IdxW'(32'(kept_ff) + 32'(DEPTH) - 32'(step_ff) - 32'd1);
   always_comb begin
      cmd_x = cmd;
      wsel = wdata;
      if (sweeping && cmd.shift && in_use && !stale) begin
         cmd_x.write = 1'b1;
         cmd_x.widx = 9'(dst);
         wsel = head;
      end
   end

   bpt_chain #(.DEPTH(DEPTH)) u_chain (
      .clock(clock), .cmd(cmd_x), .now(r_now), .wdata(wsel), .head(head)
   );

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bpt_pkg::ST_IDLE;
         count_ff <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      kept_ff <= kept_in;
      hit_ff <= hit_in;
      found_ff <= found_in;
      hit_out_ff <= hit_out_in;
      out_ff <= out_in;
      if (req.valid && req.ready) req_ff <= req.payload[bpt_pkg::ReqW-1:0];
   end

   `CHECK_ALWAYS(a_count_range, clock, reset, count_ff <= CntW'(DEPTH), "count over depth")
   `CHECK_NEXT(a_idle_ready, clock, reset, in_idle && req.valid, !in_idle, "item not taken")
   `CHECK_ALWAYS(a_hold, clock, reset, !(obusy && sweeping && cmd.shift), "shift while stalled")
endmodule

// File: src/bpt_cell.sv
// One table cell: holds an entry and can take its right neighbor's entry.
// Depends on bpt_pkg.
module bpt_cell (
   input  logic clock,
   input  logic shift,
   input  logic write_en,
   input  logic refresh,
   input  logic [bpt_pkg::TimeW-1:0] now,
   input  bpt_pkg::entry_type wdata,
   input  bpt_pkg::entry_type right,
   output bpt_pkg::entry_type q
);
   bpt_pkg::entry_type entry_ff, entry_in;

   // Next entry: refresh or write the addressed cell, else shift in neighbor.
   always_comb begin
      entry_in = entry_ff;
      if (write_en && refresh) begin
         entry_in.standing = 1'b1;
         entry_in.seen = now;
      end else if (write_en) begin
         entry_in = wdata;
      end else if (shift) begin
         entry_in = right;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign q = entry_ff;
endmodule

// File: src/bpt_chain.sv
// Row of table cells; the head cell is examined and the row rotates left.
// Depends on bpt_pkg and bpt_cell.
module bpt_chain #(parameter int DEPTH = bpt_pkg::TableDepth) (
   input  logic clock,
   input  bpt_pkg::cell_cmd_type cmd,
   input  logic [bpt_pkg::TimeW-1:0] now,
   input  bpt_pkg::entry_type wdata,
   output bpt_pkg::entry_type head
);
   bpt_pkg::entry_type q [DEPTH];

   // Rotation: the last cell takes the head so a full turn restores order.
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      bpt_cell u_cell (
         .clock(clock),
         .shift(cmd.shift),
         .write_en(cmd.write && (cmd.widx == 9'(g))),
         .refresh(cmd.refresh),
         .now(now),
         .wdata(wdata),
         .right(q[(g + 1) % DEPTH]),
         .q(q[g])
      );
   end

   assign head = q[0];
endmodule

// File: dv/beacon_presence_table_tb.sv
// Testbench of the beacon presence table: directed rows, then random phases.
// Depends on bpt_pkg, bpt_if and beacon_presence_table; predicts every result.
module beacon_presence_table_tb;

   // Item layouts on the two channels, most significant field first.
   typedef struct packed {
      logic req_type;
      logic [15:0] major_id;
      logic [15:0] minor_id;
      logic [7:0] rssi;
      logic [7:0] ref_power;
      logic [bpt_pkg::TimeW-1:0] now_us;
   } sighting_type;

   typedef struct packed {
      logic [2:0] event_res;
      logic [bpt_pkg::SlotW-1:0] slot;
      logic [15:0] tag_major;
      logic [15:0] tag_minor;
      logic [7:0] tag_rssi;
      logic [7:0] tag_ref_power;
      logic sweep_removed;
      logic last;
   } result_type;

   typedef struct {
      sighting_type item;
      bit typed;
      result_type first_event;
   } dir_row_type;

   localparam int ReqW = $bits(sighting_type);
   localparam int RspW = $bits(result_type);
   localparam logic [bpt_pkg::AgeW-1:0] AgeMax = '1;
   localparam logic [bpt_pkg::TimeW-1:0] TimeMax = '1;
   localparam int SettleCycles = bpt_pkg::TableDepth + 8;

   logic clock;
   logic reset;
   logic csr_we;
   logic [bpt_pkg::CsrIdxW-1:0] csr_idx;
   logic [bpt_pkg::CsrDataW-1:0] csr_data;

   bpt_if #(.W(ReqW)) req_ch ();
   bpt_if #(.W(RspW)) rsp_ch ();

   beacon_presence_table u_top (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .rsp(rsp_ch),
      .csr_we(csr_we),
      .csr_idx(csr_idx),
      .csr_data(csr_data)
   );

   // Shadow copy of the table and its registers.
   logic signed [7:0] pred_thr;
   logic [bpt_pkg::AgeW-1:0] pred_age_limit;
   int unsigned tag_count;
   logic [15:0] tag_major [bpt_pkg::TableDepth];
   logic [15:0] tag_minor [bpt_pkg::TableDepth];
   logic [7:0] tag_rssi [bpt_pkg::TableDepth];
   logic [7:0] tag_ref_power [bpt_pkg::TableDepth];
   logic tag_standing [bpt_pkg::TableDepth];
   logic [bpt_pkg::TimeW-1:0] tag_seen [bpt_pkg::TableDepth];

   result_type pending_events[$];
   int mismatches;
   int idle_mode;

   // Works out the events one item causes and updates the shadow table.
   function automatic void predict_events(sighting_type s, bit typed,
                                          result_type first_event);
      result_type ev;
      result_type evs[$];
      logic [bpt_pkg::TimeW-1:0] age;
      int i;
      bit found;
      found = 0;
      if (s.req_type == bpt_pkg::ReqSight) begin
         for (i = 0; i < tag_count; i++) begin
            if (!found && tag_major[i] == s.major_id && tag_minor[i] == s.minor_id) begin
               found = 1;
               ev = '{tag_standing[i] ? bpt_pkg::EvRefresh : bpt_pkg::EvAdded,
                      bpt_pkg::SlotW'(i), tag_major[i], tag_minor[i], tag_rssi[i],
                      tag_ref_power[i], 1'b0, 1'b1};
               tag_standing[i] = 1'b1;
               tag_seen[i] = s.now_us;
            end
         end
         if (!found) begin
            ev = '{bpt_pkg::EvWeak, '0, s.major_id, s.minor_id, s.rssi, s.ref_power,
                   1'b0, 1'b1};
            if ($signed(s.rssi) >= pred_thr) begin
               if (tag_count >= bpt_pkg::TableDepth) begin
                  ev.event_res = bpt_pkg::EvFull;
               end else begin
                  tag_major[tag_count] = s.major_id;
                  tag_minor[tag_count] = s.minor_id;
                  tag_rssi[tag_count] = s.rssi;
                  tag_ref_power[tag_count] = s.ref_power;
                  tag_standing[tag_count] = 1'b0;
                  tag_seen[tag_count] = s.now_us;
                  ev.event_res = bpt_pkg::EvInserted;
                  ev.slot = bpt_pkg::SlotW'(tag_count);
                  tag_count++;
               end
            end
         end
         evs.push_back(ev);
      end else begin
         // Removal compacts the table; the entry that moves down is examined next.
         i = 0;
         while (i < tag_count) begin
            age = (s.now_us >= tag_seen[i]) ? s.now_us - tag_seen[i]
                                            : tag_seen[i] - s.now_us;
            if (age > {{(bpt_pkg::TimeW-bpt_pkg::AgeW){1'b0}}, pred_age_limit}) begin
               if (tag_standing[i])
                  evs.push_back('{bpt_pkg::EvRemoved, bpt_pkg::SlotW'(i), tag_major[i],
                                  tag_minor[i], tag_rssi[i], tag_ref_power[i],
                                  1'b1, 1'b0});
               for (int j = i; j + 1 < tag_count; j++) begin
                  tag_major[j] = tag_major[j+1];
                  tag_minor[j] = tag_minor[j+1];
                  tag_rssi[j] = tag_rssi[j+1];
                  tag_ref_power[j] = tag_ref_power[j+1];
                  tag_standing[j] = tag_standing[j+1];
                  tag_seen[j] = tag_seen[j+1];
               end
               tag_count--;
            end else begin
               i++;
            end
         end
         evs.push_back('{bpt_pkg::EvRemoved, '0, '0, '0, '0, '0, 1'b0, 1'b1});
      end
      if (typed)
         evs[0] = first_event;
      foreach (evs[k])
         pending_events.push_back(evs[k]);
   endfunction

   // Clock.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Safety limit on the whole run.
   initial begin
      #(20 * 1000000);
      $display("[FAIL] regression broken");
      $finish;
   end

   // Result side: compare each taken item with the oldest prediction; stall at random unless idle_mode is 2.
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.payload;
            if (pending_events.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected event: expected none, got %p", got);
            end else begin
               want = pending_events.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("event mismatch: expected %p, got %p", want, got);
               end
            end
         end
         case (idle_mode)
            0: rsp_ch.ready <= ($urandom_range(0, 99) >= 82);
            1: rsp_ch.ready <= ($urandom_range(0, 99) >= 10);
            default: rsp_ch.ready <= 1'b1;
         endcase
      end
   end

   // Drives one item and waits for it to be taken; the caller stands at a clock edge.
   task automatic send_item(sighting_type s, bit typed, result_type first_event);
      int pct;
      pct = (idle_mode == 0) ? 10 : (idle_mode == 1) ? 82 : 0;
      if ($urandom_range(0, 99) < pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.payload <= s;
      do @(posedge clock); while (!req_ch.ready);
      predict_events(s, typed, first_event);
   endtask

   // Register write once all results are in and the row rotation has settled.
   task automatic write_config(logic signed [7:0] thr, logic [bpt_pkg::AgeW-1:0] age_lim);
      req_ch.valid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
      csr_we <= 1'b1;
      csr_idx <= bpt_pkg::CsrRssiThr;
      csr_data <= bpt_pkg::CsrDataW'(unsigned'(thr));
      @(posedge clock);
      csr_idx <= bpt_pkg::CsrAgeLimit;
      csr_data <= age_lim;
      @(posedge clock);
      csr_we <= 1'b0;
      pred_thr = thr;
      pred_age_limit = age_lim;
   endtask

   initial begin
      dir_row_type dir_rows[$];
      sighting_type s;
      result_type no_event;
      logic [15:0] key_major [48];
      logic [15:0] key_minor [48];
      logic [bpt_pkg::TimeW-1:0] clock_us;
      logic signed [7:0] thr_set [5];
      logic [bpt_pkg::AgeW-1:0] age_set [5];
      int k;

      no_event = '0;
      mismatches = 0;
      idle_mode = 2;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_idx = '0;
      csr_data = '0;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      pred_thr = -8'sd100;
      pred_age_limit = bpt_pkg::AgeLimitReset;
      tag_count = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows under the reset thresholds.
      dir_rows = '{
         '{'{bpt_pkg::ReqSweep, 16'h0, 16'h0, 8'h0, 8'h0, 48'd0}, 1,
           '{bpt_pkg::EvRemoved, 5'd0, 16'h0, 16'h0, 8'h0, 8'h0, 1'b0, 1'b1}},
         '{'{bpt_pkg::ReqSight, 16'h0, 16'h0, 8'h80, 8'h00, 48'd0}, 1,
           '{bpt_pkg::EvWeak, 5'd0, 16'h0, 16'h0, 8'h80, 8'h00, 1'b0, 1'b1}},
         '{'{bpt_pkg::ReqSight, 16'hFFFF, 16'hFFFF, 8'h7F, 8'h80, 48'd0}, 1,
           '{bpt_pkg::EvInserted, 5'd0, 16'hFFFF, 16'hFFFF, 8'h7F, 8'h80, 1'b0, 1'b1}},
         '{'{bpt_pkg::ReqSight, 16'hFFFF, 16'hFFFF, 8'h00, 8'h00, 48'd5}, 1,
           '{bpt_pkg::EvAdded, 5'd0, 16'hFFFF, 16'hFFFF, 8'h7F, 8'h80, 1'b0, 1'b1}},
         '{'{bpt_pkg::ReqSight, 16'hFFFF, 16'hFFFF, 8'h00, 8'h00, 48'd6}, 1,
           '{bpt_pkg::EvRefresh, 5'd0, 16'hFFFF, 16'hFFFF, 8'h7F, 8'h80, 1'b0, 1'b1}},
         // Exactly at the threshold is strong enough to insert.
         '{'{bpt_pkg::ReqSight, 16'h0001, 16'h0002, 8'h9C, 8'h55, TimeMax}, 1,
           '{bpt_pkg::EvInserted, 5'd1, 16'h0001, 16'h0002, 8'h9C, 8'h55, 1'b0, 1'b1}},
         // A weak sighting of a known tag still refreshes it.
         '{'{bpt_pkg::ReqSight, 16'h0001, 16'h0002, 8'h9B, 8'h11, TimeMax}, 0, no_event},
         '{'{bpt_pkg::ReqSight, 16'hAAAA, 16'h5555, 8'h00, 8'h7F, TimeMax - 1}, 0, no_event},
         '{'{bpt_pkg::ReqSight, 16'h5555, 16'hAAAA, 8'h9B, 8'h7F, 48'd9}, 1,
           '{bpt_pkg::EvWeak, 5'd0, 16'h5555, 16'hAAAA, 8'h9B, 8'h7F, 1'b0, 1'b1}},
         '{'{bpt_pkg::ReqSight, 16'h0001, 16'h0003, 8'h7F, 8'h00, TimeMax}, 0, no_event},
         // Removal of the first entry, then survivors shift down.
         '{'{bpt_pkg::ReqSweep, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, TimeMax}, 0, no_event},
         // Time wrap: old stamps near the top are far from a small time.
         '{'{bpt_pkg::ReqSweep, 16'h0, 16'h0, 8'h0, 8'h0, 48'd3}, 0, no_event},
         '{'{bpt_pkg::ReqSweep, 16'h0, 16'h0, 8'h0, 8'h0, 48'd0}, 1,
           '{bpt_pkg::EvRemoved, 5'd0, 16'h0, 16'h0, 8'h0, 8'h0, 1'b0, 1'b1}}
      };
      foreach (dir_rows[r])
         send_item(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].first_event);

      // Random phases, each with its own thresholds; the idling pattern changes after the second and fourth.
      thr_set = '{-8'sd128, 8'sd127, -8'sd60, $signed(8'($urandom)), -8'sd100};
      age_set = '{AgeMax, '0, 40'd3000, bpt_pkg::AgeW'($urandom_range(0, 4000)),
                  bpt_pkg::AgeLimitReset};
      clock_us = 48'd1000;
      for (int ph = 0; ph < 5; ph++) begin
         write_config(thr_set[ph], age_set[ph]);
         idle_mode = (ph < 2) ? 0 : (ph < 4) ? 1 : 2;
         for (int n = 0; n < 48; n++) begin
            key_major[n] = 16'($urandom);
            key_minor[n] = 16'($urandom);
         end
         for (int n = 0; n < 90; n++) begin
            clock_us = clock_us + $urandom_range(0, 1500);
            s.req_type = ($urandom_range(0, 7) == 0) ? bpt_pkg::ReqSweep : bpt_pkg::ReqSight;
            k = $urandom_range(0, 47);
            if ($urandom_range(0, 4) == 0) begin
               s.major_id = 16'($urandom);
               s.minor_id = 16'($urandom);
            end else begin
               s.major_id = key_major[k];
               s.minor_id = key_minor[k];
            end
            // Mostly strong enough to insert under the current threshold.
            if ($urandom_range(0, 3) == 0)
               s.rssi = 8'($urandom);
            else
               s.rssi = 8'($urandom_range(int'(pred_thr) + 128, 255) - 128);
            s.ref_power = 8'($urandom);
            if ($urandom_range(0, 19) == 0)
               s.now_us = {16'($urandom), 32'($urandom)};
            else
               s.now_us = clock_us;
            send_item(s, 0, no_event);
         end
      end
      req_ch.valid <= 1'b0;

      while (pending_events.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
      if (mismatches == 0 && pending_events.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// File: files.f
+incdir+src
src/bpt_pkg.sv
src/bpt_if.sv
src/bpt_cell.sv
src/bpt_chain.sv
src/beacon_presence_table.sv
dv/beacon_presence_table_tb.sv
